/* sv/canonical_huffman_table_decoder_macros.svh */
// Assertion helpers for the decoder RTL.
`ifndef CANONICAL_HUFFMAN_TABLE_DECODER_MACROS_SVH
`define CANONICAL_HUFFMAN_TABLE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define CHD_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CHD_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CHD_ASSERT_NOW(lbl, ck, rstn, ante, cons)
`define CHD_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

/* sv/chd_pkg.sv */
package chd_pkg;
	localparam int SYM_W = 9;
	localparam int LEN_W = 4;
	localparam int WIN_W = 15;
	localparam int MAX_LEN = 15;
	localparam int CODE_W = 17;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_BUILD  = 2'd1,
		KIND_DECODE = 2'd2,
		KIND_BAD    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT_RD,
		ST_CNT_USE,
		ST_SCAN,
		ST_SORT_RD,
		ST_SORT_USE,
		ST_DEC_STEP,
		ST_DEC_RD
	} state_t;
endpackage

/* sv/chd_ram.sv */
module chd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* sv/canonical_huffman_table_decoder.sv */
// Canonical Huffman decode table for a DEFLATE inflate path.
// Input items arrive on the s_ group, one result per item leaves on the m_ group.
// s_tuser selects the kind: load one code length, build the tables, or decode.
// A load transfer writes the length store and returns its result in the next cycle.
// A build counts the loaded lengths (a read and then an update per symbol), walks
// the 15 code lengths to assign canonical first codes and check for
// oversubscription, then sorts the symbols by length (a read and then a write per
// symbol). Bad counts return an error in the next cycle.
// A decode walks the bit window one code length per cycle through the compare
// unit, then reads the sorted symbol memory on a match; a miss at every length
// returns an error. The per-length walk sets the decode latency.
// Only one item is in work at a time; s_tready is low while it runs.
// The result sits in an output register until taken; a stalled receiver holds
// off the next input transfer but a result being taken frees the slot at once.
// After reset the tables are empty and every decode fails until a good build.
// The length store and sorted symbol memory are not cleared at reset.
module canonical_huffman_table_decoder #(
	parameter int MAX_SYMBOLS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// symbol_index, load_len, read_count, symbol_count, bit_window
	input  logic [47:0] s_tdata,
	// kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// symbol, used_bits, zero fill
	output logic [15:0] m_tdata,
	// status
	output logic        m_tuser
);
	import chd_pkg::*;
`include "canonical_huffman_table_decoder_macros.svh"

	localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int CW = $clog2(MAX_SYMBOLS + 1);

	logic [SYM_W-1:0] symbol_index;
	logic [LEN_W-1:0] load_len;
	logic [9:0]       read_count;
	logic [9:0]       symbol_count;
	logic [WIN_W-1:0] bit_window;
	kind_t            kind;

	assign symbol_index = s_tdata[8:0];
	assign load_len     = s_tdata[12:9];
	assign read_count   = s_tdata[22:13];
	assign symbol_count = s_tdata[32:23];
	assign bit_window   = s_tdata[47:33];
	assign kind         = kind_t'(s_tuser);

	state_t state_q, state_d;
	logic [CW-1:0]     rc_q;
	logic [CW-1:0]     i_q;
	logic [3:0]        lvl_q;
	logic [CODE_W-1:0] code_q;
	logic [CW-1:0]     total_q;
	logic [WIN_W-1:0]  win_q;
	logic [CW-1:0]     count_q [16];
	logic [15:0]       first_q [16];
	logic [CW-1:0]     base_q  [16];
	logic [CW-1:0]     next_q  [16];

	logic             acc;
	logic             bad_counts;
	logic             idx_ok;
	logic             last_sym;
	logic             lvl_last;
	logic [LEN_W-1:0] len_rd;
	logic [SYM_W-1:0] srt_rd;
	logic             len_we;
	logic             srt_we;
	logic [AW-1:0]    srt_waddr;
	logic [AW-1:0]    srt_raddr;
	logic [15:0]      dec_code;
	logic [15:0]      dec_diff;
	logic             dec_hit;
	logic [CODE_W-1:0] scan_sum;
	logic             scan_over;
	logic             fin;
	logic             fin_err;
	logic [SYM_W-1:0] fin_sym;
	logic [LEN_W-1:0] fin_used;

	assign acc        = s_tvalid && s_tready;
	assign s_tready   = (state_q == ST_IDLE) && (!m_tvalid || m_tready);
	assign bad_counts = (11'(read_count) > 11'(MAX_SYMBOLS))
		|| (11'(symbol_count) > 11'(MAX_SYMBOLS)) || (read_count > symbol_count);
	assign idx_ok     = 11'(symbol_index) < 11'(MAX_SYMBOLS);
	assign last_sym   = (i_q + CW'(1)) == rc_q;
	assign lvl_last   = lvl_q == 4'(MAX_LEN);

	assign dec_code  = {code_q[14:0], win_q[0]};
	assign dec_diff  = dec_code - first_q[lvl_q];
	assign dec_hit   = (dec_code >= first_q[lvl_q]) && (dec_diff < 16'(count_q[lvl_q]));
	assign srt_raddr = AW'(base_q[lvl_q] + dec_diff[CW-1:0]);

	assign scan_sum  = code_q + CODE_W'(count_q[lvl_q]);
	assign scan_over = (count_q[lvl_q] != '0) && (scan_sum > (CODE_W'(1) << lvl_q));

	chd_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SYMBOLS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (AW'(symbol_index)),
		.wdata (load_len),
		.raddr (i_q[AW-1:0]),
		.rdata (len_rd)
	);

	chd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_srt_ram (
		.clk   (clk),
		.we    (srt_we),
		.waddr (srt_waddr),
		.wdata (SYM_W'(i_q)),
		.raddr (srt_raddr),
		.rdata (srt_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && kind == KIND_BUILD && !bad_counts) begin
					state_d = (read_count == '0) ? ST_SCAN : ST_CNT_RD;
				end else if (acc && kind == KIND_DECODE) begin
					state_d = ST_DEC_STEP;
				end
			end
			ST_CNT_RD:   state_d = ST_CNT_USE;
			ST_CNT_USE:  state_d = last_sym ? ST_SCAN : ST_CNT_RD;
			ST_SCAN: begin
				if (scan_over) begin
					state_d = ST_IDLE;
				end else if (lvl_last) begin
					state_d = (rc_q == '0) ? ST_IDLE : ST_SORT_RD;
				end
			end
			ST_SORT_RD:  state_d = ST_SORT_USE;
			ST_SORT_USE: state_d = last_sym ? ST_IDLE : ST_SORT_RD;
			ST_DEC_STEP: begin
				if (dec_hit) begin
					state_d = ST_DEC_RD;
				end else if (lvl_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_DEC_RD:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		len_we    = acc && kind == KIND_LOAD && idx_ok;
		srt_we    = (state_q == ST_SORT_USE) && (len_rd != '0);
		srt_waddr = next_q[len_rd][AW-1:0];
		fin       = 1'b0;
		fin_err   = 1'b0;
		fin_sym   = '0;
		fin_used  = '0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (kind)
						KIND_LOAD: fin = 1'b1;
						KIND_BUILD: begin
							fin     = bad_counts;
							fin_err = bad_counts;
						end
						KIND_DECODE: fin = 1'b0;
						default: begin
							fin     = 1'b1;
							fin_err = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				fin     = scan_over || (lvl_last && rc_q == '0);
				fin_err = scan_over;
			end
			ST_SORT_USE: fin = last_sym;
			ST_DEC_STEP: begin
				fin     = !dec_hit && lvl_last;
				fin_err = !dec_hit && lvl_last;
			end
			ST_DEC_RD: begin
				fin      = 1'b1;
				fin_sym  = srt_rd;
				fin_used = lvl_q;
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
			for (int k = 0; k < 16; k++) begin
				count_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (fin) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && kind == KIND_BUILD) begin
						for (int k = 0; k < 16; k++) begin
							count_q[k] <= '0;
						end
					end
				end
				ST_CNT_USE: begin
					if (len_rd != '0) begin
						count_q[len_rd] <= count_q[len_rd] + CW'(1);
					end
				end
				ST_SCAN: begin
					if (scan_over) begin
						for (int k = 0; k < 16; k++) begin
							count_q[k] <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			m_tuser <= fin_err;
			m_tdata <= {3'b000, fin_used, fin_sym};
		end
		case (state_q)
			ST_IDLE: begin
				rc_q    <= CW'(read_count);
				i_q     <= '0;
				lvl_q   <= 4'd1;
				code_q  <= '0;
				total_q <= '0;
				win_q   <= bit_window;
			end
			ST_CNT_USE: begin
				i_q <= last_sym ? '0 : i_q + CW'(1);
			end
			ST_SCAN: begin
				first_q[lvl_q] <= code_q[15:0];
				base_q[lvl_q]  <= total_q;
				next_q[lvl_q]  <= total_q;
				code_q         <= scan_sum << 1;
				total_q        <= total_q + count_q[lvl_q];
				if (!lvl_last) begin
					lvl_q <= lvl_q + 4'd1;
				end
			end
			ST_SORT_USE: begin
				if (len_rd != '0) begin
					next_q[len_rd] <= next_q[len_rd] + CW'(1);
				end
				i_q <= i_q + CW'(1);
			end
			ST_DEC_STEP: begin
				if (!dec_hit) begin
					code_q <= CODE_W'(dec_code);
					win_q  <= win_q >> 1;
					if (!lvl_last) begin
						lvl_q <= lvl_q + 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	`CHD_ASSERT_NEXT(a_acc_busy, clk, arst_n, acc, (state_q != ST_IDLE) || m_tvalid)
	`CHD_ASSERT_NOW(a_err_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 16'd0)
	`CHD_ASSERT_NOW(a_lvl_range, clk, arst_n, state_q == ST_DEC_STEP || state_q == ST_SCAN,
		lvl_q != 4'd0)
	`CHD_ASSERT_NOW(a_fin_free, clk, arst_n, fin && state_q != ST_IDLE, !m_tvalid)
endmodule
